>>> sv/sdm_pkg.sv
// Shared types and constants for the signed-division magic number generator.
`default_nettype none

package sdm_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned ShiftW = 6;
  localparam int unsigned CntW   = 7;

  typedef struct packed {
    logic signed [DataW-1:0] divisor;
    logic                    width_is_64;
  } in_t;

  typedef struct packed {
    logic                     valid_res;
    logic signed [DataW-1:0]  multiplier;
    logic        [ShiftW-1:0] post_shift;
  } out_t;

endpackage

`default_nettype wire

>>> sv/signed_div_magic_number.sv
// A valid divisor passes through S_DIV1, S_DIV2 and the S_STEP/S_TEST doubling loop (W = 32 or 64
// word bits, n = doubling steps, 1..W) to S_DONE; a rejected divisor goes from S_IDLE straight to S_DONE.
// One transaction at a time: two radix-2 restoring divisions (one quotient bit per cycle)
// through a shared subtract/compare unit, then the doubling loop, a step state and a test state per step.
// The output register frees the input side while a result waits to be taken.
// Reset (rst_ni low, asynchronous) returns the controller to idle and drops out_valid_o.
`default_nettype none

module signed_div_magic_number (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire sdm_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output sdm_pkg::out_t     out_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_STEP = 3'd3;
  localparam logic [2:0] S_TEST = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam int unsigned DW = sdm_pkg::DataW;
  localparam int unsigned CW = sdm_pkg::CntW;
  localparam int unsigned SW = sdm_pkg::ShiftW;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          w64_q, w64_d;
  logic          ok_q, ok_d;
  logic [DW-1:0] d_q, d_d;
  logic [DW-1:0] anc_q, anc_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [DW-1:0] q2_q, q2_d;
  logic [DW-1:0] r2_q, r2_d;
  logic          out_valid_q;
  sdm_pkg::out_t out_q;

  logic          in_acc, in_bad, w64_in, load_out;
  logic [DW-1:0] d_in, div_by, rsh, rsub, t_val, anc_new;
  logic          div_ge, t_bit;
  logic [DW-1:0] r1s, r2s, delta;
  logic          ge1, ge2, pass;
  logic [CW-1:0] top_idx, w_cnt;
  logic [DW-1:0] m_raw, m_ext;
  logic [CW-1:0] sh_full;
  sdm_pkg::out_t res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign d_in   = DW'(in_data_i.divisor);
  assign w64_in = in_data_i.width_is_64;
  assign in_bad = d_in[DW-1] || (d_in[DW-2:1] == '0) || (!w64_in && (d_in[DW-2:31] != '0));

  assign top_idx = w64_q ? CW'(63) : CW'(31);
  assign w_cnt   = w64_q ? CW'(64) : CW'(32);
  assign t_val   = w64_q ? (DW'(1) << 63) : (DW'(1) << 31);

  // shared restoring division step: dividend is 2^(W-1), fed MSB first
  assign div_by  = (state_q == S_DIV1) ? d_q : anc_q;
  assign t_bit   = (cnt_q == top_idx);
  assign rsh     = {rem_q[DW-2:0], t_bit};
  assign div_ge  = (rsh >= div_by);
  assign rsub    = div_ge ? (rsh - div_by) : rsh;
  assign anc_new = t_val - DW'(1) - rsub;

  // doubling step
  assign r1s   = {rem_q[DW-2:0], 1'b0};
  assign r2s   = {r2_q[DW-2:0], 1'b0};
  assign ge1   = (r1s >= anc_q);
  assign ge2   = (r2s >= d_q);
  assign delta = d_q - r2_q;
  assign pass  = (quo_q < delta) || ((quo_q == delta) && (rem_q == '0));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    w64_d   = w64_q;
    ok_d    = ok_q;
    d_d     = d_q;
    anc_d   = anc_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    q2_d    = q2_q;
    r2_d    = r2_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          d_d   = d_in;
          w64_d = w64_in;
          ok_d  = !in_bad;
          cnt_d = w64_in ? CW'(63) : CW'(31);
          rem_d = '0;
          quo_d = '0;
          state_d = in_bad ? S_DONE : S_DIV1;
        end
      end
      S_DIV1: begin
        rem_d = rsub;
        quo_d = {quo_q[DW-2:0], div_ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          q2_d    = {quo_q[DW-2:0], div_ge};
          r2_d    = rsub;
          anc_d   = (anc_new == '0) ? DW'(1) : anc_new;
          rem_d   = '0;
          quo_d   = '0;
          cnt_d   = top_idx;
          state_d = S_DIV2;
        end
      end
      S_DIV2: begin
        rem_d = rsub;
        quo_d = {quo_q[DW-2:0], div_ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          cnt_d   = '0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cnt_d = cnt_q + CW'(1);
        quo_d = {quo_q[DW-2:0], ge1};
        rem_d = ge1 ? (r1s - anc_q) : r1s;
        q2_d  = {q2_q[DW-2:0], ge2};
        r2_d  = ge2 ? (r2s - d_q) : r2s;
        state_d = S_TEST;
      end
      S_TEST: begin
        state_d = (!pass || (cnt_q >= w_cnt)) ? S_DONE : S_STEP;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result assembly
  assign m_raw   = q2_q + DW'(1);
  assign m_ext   = w64_q ? m_raw : {{32{m_raw[31]}}, m_raw[31:0]};
  assign sh_full = cnt_q - CW'(1);

  always_comb begin
    res = '0;
    if (ok_q) begin
      res.valid_res  = 1'b1;
      res.multiplier = m_ext;
      res.post_shift = sh_full[SW-1:0];
    end
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    w64_q <= w64_d;
    ok_q  <= ok_d;
    d_q   <= d_d;
    anc_q <= anc_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    q2_q  <= q2_d;
    r2_q  <= r2_d;
    if (load_out) out_q <= res;
  end

endmodule

`default_nettype wire

>>> sv/sdm_checker.sv
// Port-level assertion checker for the magic number generator, bound to the top level.
`default_nettype none

module sdm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire sdm_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sdm_pkg::out_t out_data_o
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted transaction occupies the block on the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // a rejected divisor carries zero fields
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      (out_data_o.multiplier == '0) && (out_data_o.post_shift == '0))
    else $error("invalid result with nonzero fields");

  // out_valid_o follows a negative divisor without the division loop in between
  a_reject_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.divisor[63] |=> ##1 out_valid_o)
    else $error("negative divisor not answered");

endmodule

bind signed_div_magic_number sdm_checker u_sdm_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for signed_div_magic_number: directed and random divisors checked against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned RandomPerPhase = 176;
  localparam int unsigned WatchdogLimit  = 4000;
  localparam int unsigned DrainCycles    = 300;
  localparam int unsigned MaxReports     = 10;

  class magic_scoreboard;
    sdm_pkg::out_t pending_magic[$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   valid_seen;
    int unsigned   narrow_in;
    int unsigned   wide_in;

    function new();
      mismatches = 0;
      checked    = 0;
      valid_seen = 0;
      narrow_in  = 0;
      wide_in    = 0;
    endfunction

    function sdm_pkg::out_t predict_magic(sdm_pkg::in_t item);
      sdm_pkg::out_t res;
      bit   [63:0] d;
      bit   [63:0] t;
      bit   [63:0] anc;
      bit   [63:0] q1;
      bit   [63:0] r1;
      bit   [63:0] q2;
      bit   [63:0] r2;
      bit   [63:0] delta;
      bit   [63:0] m;
      int unsigned nbits;
      int unsigned p;
      res = '0;
      d   = item.divisor;
      if (d[63] || d <= 64'd1) return res;
      if (!item.width_is_64 && d >= 64'h8000_0000) return res;
      nbits = item.width_is_64 ? 64 : 32;
      t     = 64'd1 << (nbits - 1);
      anc   = t - 64'd1 - (t % d);
      if (anc == 64'd0) anc = 64'd1;
      q1 = t / anc;
      r1 = t - q1 * anc;
      q2 = t / d;
      r2 = t - q2 * d;
      p  = nbits - 1;
      while (1) begin
        p++;
        q1 = q1 << 1;
        r1 = r1 << 1;
        if (r1 >= anc) begin
          q1++;
          r1 = r1 - anc;
        end
        q2 = q2 << 1;
        r2 = r2 << 1;
        if (r2 >= d) begin
          q2++;
          r2 = r2 - d;
        end
        delta = d - r2;
        if (!(q1 < delta || (q1 == delta && r1 == 64'd0))) break;
        if (p >= 2 * nbits - 1) break;
      end
      m = q2 + 64'd1;
      if (!item.width_is_64) m = {{32{m[31]}}, m[31:0]};
      res.valid_res  = 1'b1;
      res.multiplier = m;
      res.post_shift = 6'(p - nbits);
      return res;
    endfunction

    function void note_divisor(sdm_pkg::in_t item);
      if (item.width_is_64) wide_in++;
      else narrow_in++;
      pending_magic.insert(pending_magic.size(), predict_magic(item));
    endfunction

    function void check_magic(sdm_pkg::out_t got);
      sdm_pkg::out_t want;
      checked++;
      if (got.valid_res) valid_seen++;
      if (pending_magic.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result valid=%0b mult=%h shift=%0d", $realtime,
                   got.valid_res, got.multiplier, got.post_shift);
        return;
      end
      want = pending_magic.pop_front();
      if (got.valid_res !== want.valid_res || got.multiplier !== want.multiplier ||
          got.post_shift !== want.post_shift) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"%0t: mismatch exp valid=%0b mult=%h shift=%0d, ",
                    "got valid=%0b mult=%h shift=%0d"},
                   $realtime, want.valid_res, want.multiplier, want.post_shift,
                   got.valid_res, got.multiplier, got.post_shift);
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  sdm_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  sdm_pkg::out_t out_data;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles   = 0;

  magic_scoreboard sb = new();

  signed_div_magic_number DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && !out_stall) sb.check_magic(out_data);
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                   quiet_cycles, sb.pending_magic.size());
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  function automatic sdm_pkg::in_t divisor_item(logic [63:0] d, logic wide);
    sdm_pkg::in_t item;
    item.divisor     = d;
    item.width_is_64 = wide;
    return item;
  endfunction

  function automatic sdm_pkg::in_t random_divisor();
    sdm_pkg::in_t item;
    int unsigned  kind;
    logic [63:0]  raw;
    kind = $urandom_range(99);
    raw  = {$urandom, $urandom};
    if (kind < 40) begin
      item = divisor_item(raw >> $urandom_range(63, 33), 1'b0);
    end else if (kind < 85) begin
      item = divisor_item(raw >> $urandom_range(63, 1), 1'b1);
    end else begin
      item = divisor_item(raw, 1'($urandom_range(1)));
    end
    return item;
  endfunction

  task automatic send_divisor(sdm_pkg::in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    sb.note_divisor(item);
    @(negedge clk_i);
  endtask

  initial begin
    sdm_pkg::in_t directed[$];
    directed.insert(directed.size(), divisor_item(64'd0, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd1, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd2, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd3, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd5, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd6, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd7, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd641, 1'b0));
    directed.insert(directed.size(), divisor_item(64'h7FFF_FFFF, 1'b0));
    directed.insert(directed.size(), divisor_item(64'h8000_0000, 1'b0));
    directed.insert(directed.size(), divisor_item(64'hFFFF_FFFF, 1'b0));
    directed.insert(directed.size(), divisor_item(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
    directed.insert(directed.size(), divisor_item(64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
    directed.insert(directed.size(), divisor_item(64'd0, 1'b1));
    directed.insert(directed.size(), divisor_item(64'd1, 1'b1));
    directed.insert(directed.size(), divisor_item(64'd2, 1'b1));
    directed.insert(directed.size(), divisor_item(64'd3, 1'b1));
    directed.insert(directed.size(), divisor_item(64'd7, 1'b1));
    directed.insert(directed.size(), divisor_item(64'hFFFF_FFFF, 1'b1));
    directed.insert(directed.size(), divisor_item(64'h1_0000_0000, 1'b1));
    directed.insert(directed.size(), divisor_item(64'h4000_0000_0000_0000, 1'b1));
    directed.insert(directed.size(), divisor_item(64'h5555_5555_5555_5555, 1'b1));
    directed.insert(directed.size(), divisor_item(64'h7FFF_FFFF_FFFF_FFFF, 1'b1));
    directed.insert(directed.size(), divisor_item(64'h8000_0000_0000_0000, 1'b1));
    directed.insert(directed.size(), divisor_item(64'hFFFF_FFFF_FFFF_FFF9, 1'b1));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct  = 21;
          recv_stall_pct = 82;
        end
        1: begin
          send_idle_pct  = 82;
          recv_stall_pct = 21;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 0) begin
        foreach (directed[i]) send_divisor(directed[i]);
      end
      repeat (RandomPerPhase) send_divisor(random_divisor());
    end
    in_valid <= 1'b0;

    while (sb.pending_magic.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d 32-bit and %0d 64-bit divisors; %0d results, %0d with a magic pair",
             sb.narrow_in, sb.wide_in, sb.checked, sb.valid_seen);
    $display("mismatches: %0d, results still outstanding: %0d", sb.mismatches,
             sb.pending_magic.size());
    if (sb.mismatches == 0 && sb.pending_magic.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
